// File: hw/rtl/tbm_pkg.sv
// Shared types, constants and helpers of the threshold binary morphology core.
package tbm_pkg;

   // Frame size limits
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   // Counter and dimension widths
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int WD_W  = COL_W + 1;
   localparam int HT_W  = ROW_W + 1;
   localparam int LAG_W = $clog2(MAX_WIDTH + 2);

   // Field and register widths
   localparam int GREY_W     = 8;
   localparam int THR_W      = 9;
   localparam int OP_W       = 2;
   localparam int DIM_CFG_W  = 11;
   localparam int CSR_DATA_W = 11;
   localparam int CSR_IDX_W  = 3;
   localparam int DIM_EXT_W  = (DIM_CFG_W > WD_W) ?
                               ((DIM_CFG_W > HT_W) ? DIM_CFG_W : HT_W) :
                               ((WD_W > HT_W) ? WD_W : HT_W);
   localparam int MIN_DIM    = 3;

   // 3x3 window geometry
   localparam int WIN_ROWS = 3;
   localparam int WIN_COLS = 3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD       = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_OPERATION       = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_EIGHT_CONNECTED = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH     = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT    = CSR_IDX_W'(4);

   // Operation codes; the unused code behaves as threshold only
   localparam logic [OP_W-1:0] OP_THRESHOLD = OP_W'(0);
   localparam logic [OP_W-1:0] OP_ERODE     = OP_W'(1);
   localparam logic [OP_W-1:0] OP_DILATE    = OP_W'(2);

   // Input command code
   localparam logic CMD_FLUSH = 1'b1;

   // Reset values of the registers
   localparam logic [THR_W-1:0]     RST_THRESHOLD = THR_W'(128);
   localparam logic [OP_W-1:0]      RST_OPERATION = OP_ERODE;
   localparam logic                 RST_EIGHT     = 1'b1;
   localparam logic [DIM_CFG_W-1:0] RST_WIDTH     = DIM_CFG_W'(640);
   localparam logic [DIM_CFG_W-1:0] RST_HEIGHT    = DIM_CFG_W'(480);

   // Words on the two channels
   typedef struct packed {
      logic              cmd;
      logic [GREY_W-1:0] grey;
   } req_word_type;

   typedef struct packed {
      logic foreground;
      logic last_of_frame;
   } rsp_word_type;

   // One line store entry: row_a is one row up, row_b two rows up
   typedef struct packed {
      logic row_a;
      logic row_b;
   } line_pair_type;

   // One window column, bit index is the row (0 top)
   typedef logic [WIN_ROWS-1:0] column_type;

   // Decisions taken when a word is accepted, carried to the window stage
   typedef struct packed {
      logic             is_pixel;
      logic             fg_bit;
      logic [COL_W-1:0] col;
      logic             emit;
      logic             border;
      logic             last;
      logic             sel_a;
   } stage_type;

   // Clamp a written dimension to MIN_DIM .. limit
   function automatic logic [DIM_EXT_W-1:0] clamp_dim(input logic [DIM_CFG_W-1:0] value,
                                                      input int unsigned limit);
      logic [DIM_EXT_W-1:0] ext;
      ext = DIM_EXT_W'(value);
      if (ext < DIM_EXT_W'(MIN_DIM)) return DIM_EXT_W'(MIN_DIM);
      if (ext > DIM_EXT_W'(limit)) return DIM_EXT_W'(limit);
      return ext;
   endfunction

endpackage

// File: hw/rtl/tbm_ram.sv
// Generic single write port, single read port RAM with registered read data.
module tbm_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/tbm_cell.sv
// Window cell: holds one 3-bit column and hands it to its left neighbor.
module tbm_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                clear,
   input  logic                shift,
   input  tbm_pkg::column_type load_col,
   output tbm_pkg::column_type held_col
);
   import tbm_pkg::*;

   column_type hold_ff;
   column_type hold_in;

   // take the column from the right neighbor on every pixel
   always_comb begin
      hold_in = hold_ff;
      if (clear) begin
         hold_in = '0;
      end else if (shift) begin
         hold_in = load_col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= '0;
      end else begin
         hold_ff <= hold_in;
      end
   end

   assign held_col = hold_ff;

endmodule

// File: hw/rtl/tbm_seq.sv
// Raster sequencer: input and output position counters, lag and per-word decisions.
module tbm_seq (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       restart,
   input  logic                       accept,
   input  tbm_pkg::req_word_type      req_data,
   input  logic [tbm_pkg::THR_W-1:0]  threshold,
   input  logic [tbm_pkg::WD_W-1:0]   width,
   input  logic [tbm_pkg::HT_W-1:0]   height,
   output tbm_pkg::stage_type         stage,
   output logic [tbm_pkg::COL_W-1:0]  rd_addr
);
   import tbm_pkg::*;

   logic [COL_W-1:0] in_col_ff, in_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;
   logic [LAG_W-1:0] lag_ff, lag_in;

   logic is_pixel;
   logic in_col_last, in_row_last;
   logic out_col_last, out_row_last;
   logic lag_full, at_origin, emit;

   // position compares
   assign is_pixel     = (req_data.cmd != CMD_FLUSH);
   assign in_col_last  = (WD_W'(in_col_ff) == width - WD_W'(1));
   assign in_row_last  = (HT_W'(in_row_ff) == height - HT_W'(1));
   assign out_col_last = (WD_W'(out_col_ff) == width - WD_W'(1));
   assign out_row_last = (HT_W'(out_row_ff) == height - HT_W'(1));
   assign lag_full     = (lag_ff == LAG_W'(width) + LAG_W'(1));
   assign at_origin    = (in_col_ff == '0) && (in_row_ff == '0);

   // a pixel emits once the window is a row plus one pixel ahead;
   // a flush emits only at a frame boundary with results pending
   assign emit = is_pixel ? lag_full : (at_origin && (lag_ff != '0));

   always_comb begin
      stage.is_pixel = is_pixel;
      stage.fg_bit   = ({1'b0, req_data.grey} < threshold);
      stage.col      = in_col_ff;
      stage.emit     = emit;
      stage.border   = !is_pixel || (out_row_ff == '0) || out_row_last ||
                       (out_col_ff == '0) || out_col_last;
      stage.last     = out_row_last && out_col_last;
      stage.sel_a    = out_row_last;
   end

   // pixels read their own column, flushes the pending output column
   assign rd_addr = is_pixel ? in_col_ff : out_col_ff;

   // counter update
   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      lag_in     = lag_ff;
      if (restart) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
         lag_in     = '0;
      end else if (accept) begin
         if (is_pixel) begin
            if (in_col_last) begin
               in_col_in = '0;
               in_row_in = in_row_last ? '0 : in_row_ff + 1'b1;
            end else begin
               in_col_in = in_col_ff + 1'b1;
            end
            if (!emit) begin
               lag_in = lag_ff + 1'b1;
            end
         end else if (emit) begin
            lag_in = lag_ff - 1'b1;
         end
         if (emit) begin
            if (out_col_last) begin
               out_col_in = '0;
               out_row_in = out_row_last ? '0 : out_row_ff + 1'b1;
            end else begin
               out_col_in = out_col_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         lag_ff     <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         lag_ff     <= lag_in;
      end
   end

endmodule

// File: hw/rtl/threshold_binary_morphology_core.sv
// Top level: thresholding, 3x3 binary erosion or dilation over two line stores.
// One word is taken per clock when the result side keeps up. A pixel word is
// accepted and its line store column read as it enters stage 1; as it leaves
// stage 1 the window cells shift, the line store is written and any result it
// emits is loaded into the output register. The result for raster position q is
// released by the pixel at q + width + 1, so each frame ends with width + 1
// pending results that flush words drain one per word; a flush elsewhere
// produces nothing. Both line stores share one 2-bit wide RAM of MAX_WIDTH
// entries with one read and one write port; it is not cleared after reset,
// and its unwritten entries only reach border results that ignore them.
// Writing the width or height restarts the stream and must only happen while
// no word is in flight.
module threshold_binary_morphology_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  tbm_pkg::req_word_type         req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output tbm_pkg::rsp_word_type         rsp_data,
   input  logic                          csr_we,
   input  logic [tbm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tbm_pkg::CSR_DATA_W-1:0] csr_data
);
   import tbm_pkg::*;

   // configuration registers
   logic [THR_W-1:0] thr_ff, thr_in;
   logic [OP_W-1:0]  op_ff, op_in;
   logic             eight_ff, eight_in;
   logic [WD_W-1:0]  width_ff, width_in;
   logic [HT_W-1:0]  height_ff, height_in;
   logic             restart;

   // pipeline
   stage_type     stage0;
   logic [COL_W-1:0] rd_addr;
   logic          accept;
   logic          s1_v_ff, s1_v_in;
   stage_type     s1_ff, s1_in;
   logic          fwd_ff, fwd_in;
   line_pair_type fwd_data_ff, fwd_data_in;
   logic          s1_adv, o_ready;
   logic          rsp_v_ff, rsp_v_in;
   rsp_word_type  rsp_ff, rsp_in;

   // line store and window
   logic [$bits(line_pair_type)-1:0] ram_q;
   line_pair_type ram_pair, rd_pair, wr_pair;
   logic          wr_en;
   column_type    chain [WIN_COLS];
   logic          centre, cross_all, cross_any, corner_all, corner_any;
   logic          nb_all, nb_any, centre_use, fg;

   // register writes; dimension writes restart the stream
   assign restart = csr_we &&
                    ((csr_index == CSR_IMAGE_WIDTH) || (csr_index == CSR_IMAGE_HEIGHT));

   always_comb begin
      thr_in    = thr_ff;
      op_in     = op_ff;
      eight_in  = eight_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_THRESHOLD: begin
               thr_in = csr_data[THR_W-1:0];
            end
            CSR_OPERATION: begin
               op_in = csr_data[OP_W-1:0];
            end
            CSR_EIGHT_CONNECTED: begin
               eight_in = csr_data[0];
            end
            CSR_IMAGE_WIDTH: begin
               width_in = WD_W'(clamp_dim(csr_data[DIM_CFG_W-1:0], MAX_WIDTH));
            end
            CSR_IMAGE_HEIGHT: begin
               height_in = HT_W'(clamp_dim(csr_data[DIM_CFG_W-1:0], MAX_HEIGHT));
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= RST_THRESHOLD;
         op_ff     <= RST_OPERATION;
         eight_ff  <= RST_EIGHT;
         width_ff  <= WD_W'(clamp_dim(RST_WIDTH, MAX_WIDTH));
         height_ff <= HT_W'(clamp_dim(RST_HEIGHT, MAX_HEIGHT));
      end else begin
         thr_ff    <= thr_in;
         op_ff     <= op_in;
         eight_ff  <= eight_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // handshake: stage 1 only blocks when it holds a result and the output is stuck
   assign o_ready   = !rsp_v_ff || !rsp_stall;
   assign s1_adv    = s1_v_ff && (!s1_ff.emit || o_ready);
   assign req_stall = s1_v_ff && !s1_adv;
   assign accept    = req_valid && !req_stall;

   tbm_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .restart   (restart),
      .accept    (accept),
      .req_data  (req_data),
      .threshold (thr_ff),
      .width     (width_ff),
      .height    (height_ff),
      .stage     (stage0),
      .rd_addr   (rd_addr)
   );

   // line stores: read on accept, written when the pixel leaves stage 1
   assign wr_en = s1_adv && s1_ff.is_pixel;

   tbm_ram #(
      .WIDTH ($bits(line_pair_type)),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_ff.col),
      .wr_data (wr_pair),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign ram_pair = ram_q;
   // a read in the same cycle as a write to its column takes the new entry
   assign rd_pair  = fwd_ff ? fwd_data_ff : ram_pair;

   always_comb begin
      wr_pair.row_a = s1_ff.fg_bit;
      wr_pair.row_b = rd_pair.row_a;
   end

   // window: newest column enters at the right, two cells keep the older ones
   assign chain[WIN_COLS-1] = {s1_ff.fg_bit, rd_pair.row_a, rd_pair.row_b};

   for (genvar k = 0; k < WIN_COLS - 1; k++) begin : g_cell
      tbm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .clear    (restart),
         .shift    (wr_en),
         .load_col (chain[k+1]),
         .held_col (chain[k])
      );
   end

   // neighborhood terms on the window after this pixel's shift
   assign centre     = chain[1][1];
   assign cross_all  = chain[1][0] & chain[0][1] & chain[2][1] & chain[1][2];
   assign cross_any  = chain[1][0] | chain[0][1] | chain[2][1] | chain[1][2];
   assign corner_all = chain[0][0] & chain[2][0] & chain[0][2] & chain[2][2];
   assign corner_any = chain[0][0] | chain[2][0] | chain[0][2] | chain[2][2];
   assign nb_all     = eight_ff ? (cross_all & corner_all) : cross_all;
   assign nb_any     = eight_ff ? (cross_any | corner_any) : cross_any;

   // flushes take the centre straight from the line store
   assign centre_use = s1_ff.is_pixel ? centre :
                       (s1_ff.sel_a ? rd_pair.row_a : rd_pair.row_b);

   always_comb begin
      case (op_ff)
         OP_THRESHOLD: fg = centre_use;
         OP_ERODE:     fg = s1_ff.border ? centre_use : (centre_use & nb_all);
         OP_DILATE:    fg = s1_ff.border ? 1'b0 : (centre_use | nb_any);
         default:      fg = centre_use;
      endcase
   end

   // stage 1 and forwarding registers
   always_comb begin
      s1_v_in     = s1_v_ff;
      s1_in       = s1_ff;
      fwd_in      = fwd_ff;
      fwd_data_in = fwd_data_ff;
      if (accept) begin
         s1_v_in     = 1'b1;
         s1_in       = stage0;
         fwd_in      = wr_en && (s1_ff.col == rd_addr);
         fwd_data_in = wr_pair;
      end else if (s1_adv) begin
         s1_v_in = 1'b0;
      end
   end

   // output register
   always_comb begin
      rsp_v_in = rsp_v_ff && rsp_stall;
      rsp_in   = rsp_ff;
      if (s1_adv && s1_ff.emit) begin
         rsp_v_in             = 1'b1;
         rsp_in.foreground    = fg;
         rsp_in.last_of_frame = s1_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff       <= s1_in;
      fwd_ff      <= fwd_in;
      fwd_data_ff <= fwd_data_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

   // forwarding only ever serves a flush word (pixels never hit the column just written)
   a_fwd_flush_only: assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff && fwd_ff) |-> !s1_ff.is_pixel)
      else $error("line store forward used by a pixel word");

   // input is stalled only behind an emitting word and a stuck output register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_v_ff && s1_ff.emit && rsp_v_ff && rsp_stall))
      else $error("input stalled without a blocked result");

   // a held stage 1 word keeps its decisions
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff && !s1_adv) |=> (s1_v_ff && (s1_ff == $past(s1_ff))))
      else $error("stage 1 word changed while held");

endmodule

// File: dv/threshold_binary_morphology_core_tb.sv
// Self-checking testbench for the threshold binary morphology core.
`timescale 1ns / 1ps

module threshold_binary_morphology_core_tb;
   import tbm_pkg::*;

   // Local codes and run constants
   localparam logic            CMD_PIXEL     = 1'b0;
   localparam logic [OP_W-1:0] OP_UNUSED     = OP_W'(3);
   localparam int              SETTLE_CYCLES = 12;
   localparam int              RANDOM_WORDS  = 100;

   // DUT connections
   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_word_type          req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_word_type          rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   // Predicted register contents
   logic [THR_W-1:0]     thr_reg    = RST_THRESHOLD;
   logic [OP_W-1:0]      op_reg     = RST_OPERATION;
   logic                 eight_reg  = RST_EIGHT;
   logic [DIM_CFG_W-1:0] width_reg  = RST_WIDTH;
   logic [DIM_CFG_W-1:0] height_reg = RST_HEIGHT;

   // Predicted stream state
   bit          row_one_up [MAX_WIDTH];
   bit          row_two_up [MAX_WIDTH];
   bit [8:0]    win_cells;
   int unsigned in_col;
   int unsigned in_row;
   int unsigned out_pos;

   rsp_word_type expected_pixels [$];
   rsp_word_type oldest;

   // Bookkeeping
   int burst_left      = 0;
   int stall_mode      = 0;
   int stall_left      = 0;
   int counted_words   = 0;
   int pixel_words     = 0;
   int flush_words     = 0;
   int reg_writes      = 0;
   int results_checked = 0;
   int mismatches      = 0;

   threshold_binary_morphology_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop
   initial begin
      #50_000_000;
      $display("threshold_binary_morphology_core_tb: FAIL");
      $finish;
   end

   // Frame dimension after clamping
   function automatic int unsigned eff_dim(input logic [DIM_CFG_W-1:0] raw,
                                           input int unsigned hi);
      int unsigned v;
      v = raw;
      return (v < MIN_DIM) ? MIN_DIM : ((v > hi) ? hi : v);
   endfunction

   function automatic void restart_stream_model();
      win_cells = '0;
      in_col    = 0;
      in_row    = 0;
      out_pos   = 0;
   endfunction

   // Morphology predictor: returns 1 when the word releases a result pixel
   function automatic bit predict_morph(input req_word_type word, output rsp_word_type pix);
      int unsigned w, h, frame, inpos, lag, r, c, col;
      bit          border, fg_in, up1, up2, centre, all_nb, any_nb, fg;
      w      = eff_dim(width_reg, MAX_WIDTH);
      h      = eff_dim(height_reg, MAX_HEIGHT);
      frame  = w * h;
      inpos  = in_row * w + in_col;
      lag    = (inpos >= out_pos) ? inpos - out_pos : inpos + frame - out_pos;
      r      = out_pos / w;
      c      = out_pos % w;
      border = (r == 0) || (r == h - 1) || (c == 0) || (c == w - 1);
      pix    = '0;
      all_nb = 1'b0;
      any_nb = 1'b0;
      if (word.cmd == CMD_PIXEL) begin
         // shift the line stores and the window, then advance the raster
         fg_in = (word.grey < thr_reg);
         col   = in_col;
         up2   = row_two_up[col];
         up1   = row_one_up[col];
         row_two_up[col] = up1;
         row_one_up[col] = fg_in;
         win_cells = {fg_in, up1, up2, win_cells[8:3]};
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
            if (in_row >= h) in_row = 0;
         end
         if (lag < w + 1) return 1'b0;
         // cell index is column * 3 + row
         centre = win_cells[4];
         all_nb = win_cells[3] & win_cells[1] & win_cells[7] & win_cells[5];
         any_nb = win_cells[3] | win_cells[1] | win_cells[7] | win_cells[5];
         if (eight_reg) begin
            all_nb = all_nb & win_cells[0] & win_cells[6] & win_cells[2] & win_cells[8];
            any_nb = any_nb | win_cells[0] | win_cells[6] | win_cells[2] | win_cells[8];
         end
      end else begin
         // flush drains only at a frame boundary with results pending
         if (inpos != 0 || lag == 0) return 1'b0;
         centre = (r == h - 1) ? row_one_up[c] : row_two_up[c];
         border = 1'b1;
      end
      case (op_reg)
         OP_ERODE:  fg = border ? centre : (centre & all_nb);
         OP_DILATE: fg = border ? 1'b0 : (centre | any_nb);
         default:   fg = centre;
      endcase
      pix.foreground    = fg;
      pix.last_of_frame = (out_pos == frame - 1);
      out_pos++;
      if (out_pos >= frame) out_pos = 0;
      return 1'b1;
   endfunction

   // Grey level that lands on the wanted side of the threshold when possible
   function automatic logic [GREY_W-1:0] grey_for(input bit want_fg);
      int unsigned thr;
      thr = thr_reg;
      if (want_fg && thr > 0)
         return GREY_W'($urandom_range(0, (thr > 256) ? 255 : thr - 1));
      if (!want_fg && thr < 256)
         return GREY_W'($urandom_range(thr, 255));
      return GREY_W'($urandom_range(0, 255));
   endfunction

   task automatic flag_error(input string msg);
      mismatches++;
      $display("%0t: %s", $time, msg);
   endtask

   // Send one word in bursts with random gaps; predict on acceptance
   task automatic send_word(input logic cmd, input logic [GREY_W-1:0] grey);
      req_word_type word;
      rsp_word_type pix;
      int           gap;
      word.cmd  = cmd;
      word.grey = grey;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      req_valid <= 1'b1;
      req_data  <= word;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      if (cmd == CMD_PIXEL) pixel_words++;
      else flush_words++;
      if (predict_morph(word, pix)) begin
         expected_pixels = {expected_pixels, pix};
         counted_words++;
      end else if (cmd == CMD_PIXEL) begin
         counted_words++;
      end
   endtask

   task automatic send_pixels(input int n, input int fg_pct);
      for (int i = 0; i < n; i++)
         send_word(CMD_PIXEL, grey_for($urandom_range(0, 99) < fg_pct));
   endtask

   task automatic send_flushes(input int n);
      for (int i = 0; i < n; i++)
         send_word(CMD_FLUSH, GREY_W'($urandom_range(0, 255)));
   endtask

   task automatic send_frame(input int fg_pct);
      send_pixels(eff_dim(width_reg, MAX_WIDTH) * eff_dim(height_reg, MAX_HEIGHT), fg_pct);
   endtask

   task automatic drain_frame();
      send_flushes(eff_dim(width_reg, MAX_WIDTH) + 1);
   endtask

   // Stop sending, wait for every predicted result, let the pipeline empty
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write; only called while the core is idle
   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      case (index)
         CSR_THRESHOLD:       thr_reg   = data[THR_W-1:0];
         CSR_OPERATION:       op_reg    = data[OP_W-1:0];
         CSR_EIGHT_CONNECTED: eight_reg = data[0];
         CSR_IMAGE_WIDTH: begin
            width_reg = data[DIM_CFG_W-1:0];
            restart_stream_model();
         end
         CSR_IMAGE_HEIGHT: begin
            height_reg = data[DIM_CFG_W-1:0];
            restart_stream_model();
         end
         default: ;
      endcase
      reg_writes++;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_dims(input int w, input int h);
      write_reg(CSR_IMAGE_WIDTH, CSR_DATA_W'(w));
      write_reg(CSR_IMAGE_HEIGHT, CSR_DATA_W'(h));
   endtask

   // 3x3 frame from a bit pattern, raster order, then drained
   task automatic send_pattern(input bit [8:0] pattern);
      for (int i = 0; i < 9; i++)
         send_word(CMD_PIXEL, pattern[i] ? GREY_W'(0) : GREY_W'(255));
      send_flushes(4);
   endtask

   // Reset values: 640 wide, threshold 128, 8-connected erosion
   task automatic check_reset_defaults();
      send_word(CMD_PIXEL, GREY_W'(127));
      send_word(CMD_PIXEL, GREY_W'(128));
      send_word(CMD_PIXEL, GREY_W'(0));
      send_word(CMD_PIXEL, GREY_W'(255));
      send_pixels(641, 85);
      drain_results();
   endtask

   // Every operation code; erosion and dilation under both connectivities
   task automatic check_operations();
      logic [OP_W-1:0] ops    [6] = '{OP_THRESHOLD, OP_ERODE, OP_ERODE,
                                     OP_DILATE, OP_DILATE, OP_UNUSED};
      bit              eights [6] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
      set_dims(3, 3);
      write_reg(CSR_THRESHOLD, CSR_DATA_W'(128));
      for (int k = 0; k < 6; k++) begin
         write_reg(CSR_OPERATION, CSR_DATA_W'(ops[k]));
         write_reg(CSR_EIGHT_CONNECTED, CSR_DATA_W'(eights[k]));
         // plus shape survives 4-connected erosion only; corners grow 8-connected only
         send_pattern(9'h0BA);
         send_pattern(9'h145);
         drain_results();
      end
   endtask

   // Threshold extremes, including values past the grey range
   task automatic check_thresholds();
      int              thr_list [7] = '{0, 1, 127, 128, 255, 256, 511};
      logic [GREY_W-1:0] greys  [8] = '{0, 1, 126, 127, 128, 129, 254, 255};
      write_reg(CSR_OPERATION, CSR_DATA_W'(OP_THRESHOLD));
      for (int k = 0; k < 7; k++) begin
         write_reg(CSR_THRESHOLD, CSR_DATA_W'(thr_list[k]));
         for (int i = 0; i < 8; i++) send_word(CMD_PIXEL, greys[i]);
         send_word(CMD_PIXEL, GREY_W'($urandom_range(0, 255)));
         send_flushes(4);
         drain_results();
      end
   endtask

   // Ignored flushes, partial drain, frames back to back, restart mid frame
   task automatic check_flush_rules();
      write_reg(CSR_THRESHOLD, CSR_DATA_W'(128));
      write_reg(CSR_OPERATION, CSR_DATA_W'(OP_ERODE));
      write_reg(CSR_EIGHT_CONNECTED, CSR_DATA_W'(1));
      set_dims(3, 3);
      send_flushes(1);
      send_pixels(2, 60);
      send_flushes(1);
      send_pixels(7, 60);
      send_flushes(2);
      send_frame(60);
      send_flushes(4);
      send_flushes(2);
      send_pixels(5, 60);
      drain_results();
      write_reg(CSR_IMAGE_HEIGHT, CSR_DATA_W'(3));
      send_frame(60);
      drain_frame();
      drain_results();
   endtask

   // Frame sizes below the minimum
   task automatic check_dimension_limits();
      int ws [3] = '{0, 1, 2};
      int hs [3] = '{2, 0, 1};
      write_reg(CSR_OPERATION, CSR_DATA_W'(OP_DILATE));
      for (int k = 0; k < 3; k++) begin
         set_dims(ws[k], hs[k]);
         send_frame(70);
         drain_frame();
         drain_results();
      end
   endtask

   function automatic int pick_dim();
      int k;
      k = $urandom_range(0, 99);
      if (k < 4) return $urandom_range(0, 2);
      if (k < 90) return $urandom_range(3, 12);
      return $urandom_range(13, 16);
   endfunction

   function automatic int pick_threshold();
      case ($urandom_range(0, 11))
         0:       return 0;
         1:       return 1;
         2:       return 255;
         3:       return 256;
         4:       return $urandom_range(257, 511);
         default: return $urandom_range(30, 230);
      endcase
   endfunction

   // New settings between phases; junk above the threshold, operation and connectivity fields
   task automatic random_setup();
      drain_results();
      if ($urandom_range(0, 4) != 0) set_dims(pick_dim(), pick_dim());
      write_reg(CSR_THRESHOLD,
                CSR_DATA_W'(pick_threshold() | ($urandom_range(0, 3) << THR_W)));
      write_reg(CSR_OPERATION,
                CSR_DATA_W'($urandom_range(0, 3) | ($urandom_range(0, 511) << OP_W)));
      write_reg(CSR_EIGHT_CONNECTED,
                CSR_DATA_W'($urandom_range(0, 1) | ($urandom_range(0, 1023) << 1)));
      if ($urandom_range(0, 9) == 0)
         write_reg(CSR_IDX_W'($urandom_range(CSR_IMAGE_HEIGHT + 1, 7)),
                   CSR_DATA_W'($urandom_range(0, 2047)));
   endtask

   // Mostly complete frames with random content, some broken sequences
   task automatic run_random_frames();
      int stop_at, frames_left, variant, fg_pct;
      stop_at     = counted_words + RANDOM_WORDS;
      frames_left = 0;
      while (counted_words < stop_at) begin
         if (frames_left == 0) begin
            random_setup();
            frames_left = $urandom_range(1, 4);
         end
         frames_left--;
         fg_pct  = $urandom_range(10, 95);
         variant = $urandom_range(0, 99);
         if (variant < 65) begin
            send_frame(fg_pct);
            drain_frame();
            if ($urandom_range(0, 4) == 0) send_flushes($urandom_range(1, 3));
         end else if (variant < 80) begin
            send_frame(fg_pct);
         end else if (variant < 90) begin
            send_frame(fg_pct);
            send_flushes($urandom_range(1, eff_dim(width_reg, MAX_WIDTH)));
         end else begin
            // noise: flushes scattered through a partial stream
            repeat ($urandom_range(5, 40)) begin
               if ($urandom_range(0, 9) < 3)
                  send_flushes(1);
               else
                  send_word(CMD_PIXEL, GREY_W'($urandom_range(0, 255)));
            end
         end
      end
   endtask

   // Result side: stall pattern that switches between modes
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(5, 60);
      end
      stall_left--;
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 3) == 0);
         2:       rsp_stall <= $urandom_range(0, 1);
         default: rsp_stall <= ($urandom_range(0, 9) < 8);
      endcase
   end

   // Compare each accepted result word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            flag_error($sformatf("result fg=%b last=%b, expected none",
                                 rsp_data.foreground, rsp_data.last_of_frame));
         end else begin
            oldest = expected_pixels.pop_front();
            if (rsp_data.foreground !== oldest.foreground)
               flag_error($sformatf("foreground expected %b actual %b",
                                    oldest.foreground, rsp_data.foreground));
            if (rsp_data.last_of_frame !== oldest.last_of_frame)
               flag_error($sformatf("last_of_frame expected %b actual %b",
                                    oldest.last_of_frame, rsp_data.last_of_frame));
            results_checked++;
         end
      end
   end

   // Test sequence
   initial begin
      restart_stream_model();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_reset_defaults();
      check_operations();
      check_thresholds();
      check_flush_rules();
      check_dimension_limits();
      run_random_frames();
      drain_results();
      $display("covered %0d pixel words and %0d flush words across %0d register writes",
               pixel_words, flush_words, reg_writes);
      $display("compared %0d result words, %0d mismatches", results_checked, mismatches);
      if (mismatches == 0)
         $display("threshold_binary_morphology_core_tb: PASS");
      else
         $display("threshold_binary_morphology_core_tb: FAIL");
      $finish;
   end

endmodule

// File: files.f
hw/rtl/tbm_pkg.sv
hw/rtl/tbm_ram.sv
hw/rtl/tbm_cell.sv
hw/rtl/tbm_seq.sv
hw/rtl/threshold_binary_morphology_core.sv
dv/threshold_binary_morphology_core_tb.sv
